@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/pidaxs_pkg.sv @@
// Types and constants for the PID axis with slew limit.
package pidaxs_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned INTG_W = 64;
    localparam int unsigned PER_W  = 16;
    localparam int unsigned LIM_W  = 31;
    localparam int unsigned CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN       = 4'd0,
        CFG_KI_GAIN       = 4'd1,
        CFG_KD_GAIN       = 4'd2,
        CFG_SAMPLE_PERIOD = 4'd3,
        CFG_OUTPUT_LIMIT  = 4'd4,
        CFG_ACCEL_RATE    = 4'd5,
        CFG_DECEL_RATE    = 4'd6,
        CFG_LOOP_MODE     = 4'd7
    } cfg_index_t;

    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_VELOCITY = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured;
        logic signed [DATA_W-1:0] setpoint;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] command;
        logic signed [DATA_W-1:0] error_now;
    } out_word_t;

endpackage

@@ rtl/pid_axis_with_slew_limit.sv @@
// PID axis: trapezoidal integral, derivative divider, clamp and slew limit.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid / in_ready   | in_data  (measured, setpoint)
//  out     | output    | out_valid / out_ready | out_data (command, error_now)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word at a time: a new word is accepted only after the last result is
// registered. The pace is set by one radix-2 shift-add multiplier doing six
// 32-step products in turn; the 49-step restoring divider runs alongside.
// Reset (rst_n low, async) loads register defaults and clears loop state.
// The result sits in an output register, so a stalled consumer only holds
// the next word at its final slew step; cfg_ready is always high.

`include "assert_macros.svh"

module pid_axis_with_slew_limit
    import pidaxs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    localparam int unsigned MR_W   = 32;            // multiplier operand
    localparam int unsigned MD_W   = 64;            // multiplicand operand
    localparam int unsigned PROD_W = MR_W + MD_W;
    localparam int unsigned DVD_W  = DATA_W + 1 + PER_W; // |diff| << 16
    localparam int unsigned W34    = DATA_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_INC, S_INT, S_P, S_PW, S_IK, S_IKW,
        S_DK, S_DKW, S_UP, S_UPW, S_DN, S_DNW, S_SLEW
    } state_t;

    // ---------------- helpers ----------------
    function automatic logic [DATA_W-1:0] sat34(input logic [W34-1:0] v);
        logic [DATA_W-1:0] r;
        begin
            r = v[DATA_W-1:0];
            if (!v[W34-1] && (v[W34-2] || v[DATA_W-1]))
                r = {1'b0, {(DATA_W-1){1'b1}}};
            else if (v[W34-1] && !(v[W34-2] && v[DATA_W-1]))
                r = {1'b1, {(DATA_W-1){1'b0}}};
            return r;
        end
    endfunction

    function automatic logic [W34-1:0] sx34(input logic [DATA_W-1:0] v);
        return {{2{v[DATA_W-1]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // signed result from sign and magnitude, saturated to DATA_W bits
    function automatic logic [DATA_W-1:0] mag_to_s32(input logic neg,
                                                     input logic [PROD_W-1:0] m);
        logic ovp;
        logic ovn;
        logic [DATA_W-1:0] r;
        begin
            ovp = |m[PROD_W-1:DATA_W-1];
            ovn = (|m[PROD_W-1:DATA_W]) | (m[DATA_W-1] & (|m[DATA_W-2:0]));
            if (neg)
                r = ovn ? {1'b1, {(DATA_W-1){1'b0}}} : (~m[DATA_W-1:0] + 1'b1);
            else
                r = ovp ? {1'b0, {(DATA_W-1){1'b1}}} : m[DATA_W-1:0];
            return r;
        end
    endfunction

    // ---------------- registers ----------------
    state_t                 state_reg;
    logic [DATA_W-1:0]      kp_reg, ki_reg, kd_reg;
    logic [PER_W-1:0]       per_reg;
    logic [LIM_W-1:0]       limit_reg, accel_reg, decel_reg;
    logic                   mode_reg;

    logic [DATA_W-1:0]      err_reg, last_err_reg, last_cmd_reg;
    logic [INTG_W-1:0]      integral_reg;
    logic [DATA_W-1:0]      p_reg, ik_reg, dk_reg, cmd_reg;
    logic [LIM_W-1:0]       up_reg, down_reg;

    logic [MD_W-1:0]        mul_hi_reg, mul_md_reg;
    logic [MR_W-1:0]        mul_lo_reg;
    logic [4:0]             mul_cnt_reg;
    logic                   neg_reg;

    logic [DVD_W-1:0]       div_q_reg;
    logic [PER_W-1:0]       div_r_reg;
    logic [5:0]             div_cnt_reg;
    logic                   div_busy_reg;
    logic                   deriv_neg_reg;

    logic                   out_valid_reg;
    out_word_t              out_reg;

    // ---------------- datapath ----------------
    logic                   mul_run;
    logic [MD_W:0]          mul_sum;
    logic [PROD_W-1:0]      prod;
    logic [PER_W:0]         div_trial;
    logic                   div_ge;
    logic [W34-1:0]         err34;
    logic [DATA_W:0]        diff33, sum33, diff_mag, sum_mag;
    logic [INTG_W-1:0]      inc_mag, inc_val;
    logic [INTG_W:0]        intg_sum;
    logic [INTG_W-1:0]      integral_next;
    logic [DATA_W-1:0]      deriv_s;
    logic [INTG_W-1:0]      intg_abs;
    logic [DATA_W-1:0]      pid_sum, cmd_clamped;
    logic [W34-1:0]         lim34, c34, delta34, up34, down34;
    logic [DATA_W-1:0]      cmd_next;
    logic                   out_free;

    assign mul_run = (state_reg == S_INC) || (state_reg == S_P) || (state_reg == S_IK)
                  || (state_reg == S_DK) || (state_reg == S_UP) || (state_reg == S_DN);
    assign mul_sum = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_md_reg} : '0);
    assign prod    = {mul_hi_reg, mul_lo_reg};

    assign div_trial = {div_r_reg, div_q_reg[DVD_W-1]};
    assign div_ge    = div_trial >= {1'b0, per_reg};

    assign err34 = sx34(in_data.setpoint) - sx34(in_data.measured);

    assign diff33   = {err_reg[DATA_W-1], err_reg} - {last_err_reg[DATA_W-1], last_err_reg};
    assign sum33    = {err_reg[DATA_W-1], err_reg} + {last_err_reg[DATA_W-1], last_err_reg};
    assign diff_mag = diff33[DATA_W] ? (~diff33 + 1'b1) : diff33;
    assign sum_mag  = sum33[DATA_W] ? (~sum33 + 1'b1) : sum33;

    // trapezoid increment: |err + prev| * period / 2, sign restored
    assign inc_mag  = prod[INTG_W:1];
    assign inc_val  = neg_reg ? (~inc_mag + 1'b1) : inc_mag;
    assign intg_sum = {integral_reg[INTG_W-1], integral_reg}
                    + {inc_val[INTG_W-1], inc_val};
    always_comb
    begin
        integral_next = intg_sum[INTG_W-1:0];
        if (intg_sum[INTG_W] != intg_sum[INTG_W-1])
            integral_next = intg_sum[INTG_W] ? {1'b1, {(INTG_W-1){1'b0}}}
                                             : {1'b0, {(INTG_W-1){1'b1}}};
    end

    assign intg_abs = integral_reg[INTG_W-1] ? (~integral_reg + 1'b1) : integral_reg;
    assign deriv_s  = (per_reg == '0) ? '0
                    : mag_to_s32(deriv_neg_reg, {{(PROD_W-DVD_W){1'b0}}, div_q_reg});

    // sum of the three terms, then symmetric clamp
    assign pid_sum = sat34(sx34(p_reg) + sx34(ik_reg) + sx34(dk_reg));
    assign lim34   = {3'b0, limit_reg};
    assign c34     = sx34(pid_sum);
    always_comb
    begin
        cmd_clamped = pid_sum;
        if ($signed(c34) > $signed(lim34))
            cmd_clamped = {1'b0, limit_reg};
        else if ($signed(c34) < -$signed(lim34))
            cmd_clamped = ~{1'b0, limit_reg} + 1'b1;
    end

    // slew limit against the last emitted command (position mode only)
    assign up34    = {3'b0, up_reg};
    assign down34  = {3'b0, down_reg};
    assign delta34 = sx34(cmd_reg) - sx34(last_cmd_reg);
    always_comb
    begin
        cmd_next = cmd_reg;
        if (mode_reg == MODE_POSITION) begin
            if ($signed(delta34) > $signed(up34))
                cmd_next = sat34(sx34(last_cmd_reg) + up34);
            else if ($signed(delta34) < -$signed(down34))
                cmd_next = sat34(sx34(last_cmd_reg) - down34);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            kp_reg        <= 32'h0001_0000;
            ki_reg        <= '0;
            kd_reg        <= '0;
            per_reg       <= 16'd655;
            limit_reg     <= {LIM_W{1'b1}};
            accel_reg     <= {LIM_W{1'b1}};
            decel_reg     <= {LIM_W{1'b1}};
            mode_reg      <= MODE_POSITION;
            last_err_reg  <= '0;
            last_cmd_reg  <= '0;
            integral_reg  <= '0;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            div_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_KP_GAIN:       kp_reg    <= cfg_data;
                    CFG_KI_GAIN:       ki_reg    <= cfg_data;
                    CFG_KD_GAIN:       kd_reg    <= cfg_data;
                    CFG_SAMPLE_PERIOD: per_reg   <= cfg_data[PER_W-1:0];
                    CFG_OUTPUT_LIMIT:  limit_reg <= cfg_data[LIM_W-1:0];
                    CFG_ACCEL_RATE:    accel_reg <= cfg_data[LIM_W-1:0];
                    CFG_DECEL_RATE:    decel_reg <= cfg_data[LIM_W-1:0];
                    CFG_LOOP_MODE:     mode_reg  <= cfg_data[0];
                    default:           ;
                endcase
            end

            // a word leaving while the next one is emitted is handled in S_SLEW
            if (out_valid_reg && out_ready && (state_reg != S_SLEW))
                out_valid_reg <= 1'b0;

            // shift-add multiplier step
            if (mul_run) begin
                mul_hi_reg  <= mul_sum[MD_W:1];
                mul_lo_reg  <= {mul_sum[0], mul_lo_reg[MR_W-1:1]};
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end

            // restoring divider step
            if (div_busy_reg) begin
                div_r_reg   <= div_ge ? PER_W'(div_trial - {1'b0, per_reg})
                                      : div_trial[PER_W-1:0];
                div_q_reg   <= {div_q_reg[DVD_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == 6'(DVD_W - 1))
                    div_busy_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) begin
                        err_reg   <= sat34(err34);
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    div_q_reg     <= {diff_mag, {PER_W{1'b0}}};
                    div_r_reg     <= '0;
                    div_cnt_reg   <= '0;
                    div_busy_reg  <= 1'b1;
                    deriv_neg_reg <= diff33[DATA_W];
                    last_err_reg  <= err_reg;
                    mul_hi_reg    <= '0;
                    mul_lo_reg    <= {{(MR_W-PER_W){1'b0}}, per_reg};
                    mul_md_reg    <= {{(MD_W-DATA_W-1){1'b0}}, sum_mag};
                    neg_reg       <= sum33[DATA_W];
                    state_reg     <= S_INC;
                end
                S_INT:
                begin
                    integral_reg <= integral_next;
                    mul_hi_reg   <= '0;
                    mul_lo_reg   <= abs32(kp_reg);
                    mul_md_reg   <= {{(MD_W-DATA_W){1'b0}}, abs32(err_reg)};
                    neg_reg      <= kp_reg[DATA_W-1] ^ err_reg[DATA_W-1];
                    state_reg    <= S_P;
                end
                S_PW:
                begin
                    p_reg      <= mag_to_s32(neg_reg, prod >> 16);
                    mul_hi_reg <= '0;
                    mul_lo_reg <= abs32(ki_reg);
                    mul_md_reg <= intg_abs;
                    neg_reg    <= ki_reg[DATA_W-1] ^ integral_reg[INTG_W-1];
                    state_reg  <= S_IK;
                end
                S_IKW:
                begin
                    ik_reg     <= mag_to_s32(neg_reg, prod >> 32);
                    mul_hi_reg <= '0;
                    mul_lo_reg <= abs32(kd_reg);
                    mul_md_reg <= {{(MD_W-DATA_W){1'b0}}, abs32(deriv_s)};
                    neg_reg    <= kd_reg[DATA_W-1] ^ deriv_s[DATA_W-1];
                    state_reg  <= S_DK;
                end
                S_DKW:
                begin
                    dk_reg     <= mag_to_s32(neg_reg, prod >> 16);
                    mul_hi_reg <= '0;
                    mul_lo_reg <= {{(MR_W-PER_W){1'b0}}, per_reg};
                    mul_md_reg <= {{(MD_W-LIM_W){1'b0}}, accel_reg};
                    neg_reg    <= 1'b0;
                    state_reg  <= S_UP;
                end
                S_UPW:
                begin
                    up_reg     <= prod[LIM_W+15:16];
                    mul_hi_reg <= '0;
                    mul_lo_reg <= {{(MR_W-PER_W){1'b0}}, per_reg};
                    mul_md_reg <= {{(MD_W-LIM_W){1'b0}}, decel_reg};
                    state_reg  <= S_DN;
                end
                S_DNW:
                begin
                    down_reg  <= prod[LIM_W+15:16];
                    cmd_reg   <= cmd_clamped;
                    state_reg <= S_SLEW;
                end
                S_SLEW:
                begin
                    if (out_free) begin
                        last_cmd_reg      <= cmd_next;
                        out_reg.command   <= cmd_next;
                        out_reg.error_now <= err_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_INC, S_P, S_IK, S_DK, S_UP, S_DN:
                begin
                    if (mul_cnt_reg == 5'(MR_W - 1)) begin
                        case (state_reg)
                            S_INC:   state_reg <= S_INT;
                            S_P:     state_reg <= S_PW;
                            S_IK:    state_reg <= S_IKW;
                            S_DK:    state_reg <= S_DKW;
                            S_UP:    state_reg <= S_UPW;
                            default: state_reg <= S_DNW;
                        endcase
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // ---------------- checks ----------------
    `ASSERT_SAME(a_div_done, clk, rst_n, state_reg == S_IKW, !div_busy_reg)
    `ASSERT_SAME(a_mul_idle, clk, rst_n, state_reg == S_IDLE, mul_cnt_reg == '0)
    `ASSERT_NEXT(a_result_out, clk, rst_n, (state_reg == S_SLEW) && out_free, out_valid_reg && (state_reg == S_IDLE))

endmodule

@@ bench/tb_pid_axis_with_slew_limit.sv @@
// Testbench for the PID axis with slew limit: queued stimulus, bit-exact predictor, scoreboard.
module tb_pid_axis_with_slew_limit;
    import pidaxs_pkg::*;

    // Wide signed type: products of 64-bit magnitudes never overflow it.
    typedef logic signed [127:0] wide_t;

    typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_kind_t;

    typedef struct {
        act_kind_t   kind;
        in_word_t    word;
        cfg_index_t  idx;
        logic [31:0] data;
    } action_t;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_KP_GAIN;
    logic [31:0] cfg_data = '0;

    pid_axis_with_slew_limit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial forever #2 clk = ~clk;

    action_t   pending[$];
    out_word_t expected_words[$];

    int words_sent = 0;
    int words_seen = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int quiet_cycles = 0;   // cycles since the last expected word drained
    int stalled = 0;        // cycles without any handshake

    // Mirror of the controller registers and loop state.
    wide_t kp = 65536, ki = 0, kd = 0;
    wide_t period = 655, limit = 32'h7FFF_FFFF;
    wide_t accel = 32'h7FFF_FFFF, decel = 32'h7FFF_FFFF;
    logic  mode = MODE_POSITION;
    wide_t prev_error = 0, integral = 0, prev_command = 0;

    // No idling while this many words have been sent: one calm stretch.
    function automatic bit calm_stretch();
        return words_sent >= 500 && words_sent < 700;
    endfunction

    function automatic wide_t clamp_w(wide_t v, int w);
        wide_t hi;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic wide_t abs_w(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Product scaled by 2^-sh, truncated toward zero, saturated to w bits.
    function automatic wide_t scaled_product(wide_t a, wide_t b, int sh, int w);
        wide_t m;
        m = (abs_w(a) * abs_w(b)) >>> sh;
        return clamp_w(((a < 0) != (b < 0)) ? -m : m, w);
    endfunction

    function automatic out_word_t pid_sample(in_word_t w);
        wide_t err, diff, deriv, incr, p_term, i_term, d_term, cmd, up, down;
        out_word_t r;
        err = clamp_w(wide_t'(w.setpoint) - wide_t'(w.measured), DATA_W);
        deriv = 0;
        if (period != 0)
        begin
            diff = err - prev_error;
            deriv = (abs_w(diff) <<< 16) / period;
            deriv = clamp_w((diff < 0) ? -deriv : deriv, DATA_W);
        end
        incr = scaled_product(err + prev_error, period, 1, INTG_W);
        integral = clamp_w(integral + incr, INTG_W);
        prev_error = err;
        p_term = scaled_product(kp, err, 16, DATA_W);
        i_term = scaled_product(ki, integral, 32, DATA_W);
        d_term = scaled_product(kd, deriv, 16, DATA_W);
        cmd = clamp_w(p_term + i_term + d_term, DATA_W);
        if (cmd > limit)
            cmd = limit;
        else if (cmd < -limit)
            cmd = -limit;
        if (mode == MODE_POSITION)
        begin
            up = scaled_product(accel, period, 16, DATA_W);
            down = scaled_product(decel, period, 16, DATA_W);
            if (cmd - prev_command > up)
                cmd = clamp_w(prev_command + up, DATA_W);
            else if (cmd - prev_command < -down)
                cmd = clamp_w(prev_command - down, DATA_W);
        end
        prev_command = cmd;
        r.command = cmd[31:0];
        r.error_now = err[31:0];
        return r;
    endfunction

    task automatic write_register(cfg_index_t i, logic [31:0] d);
        case (i)
            CFG_KP_GAIN:       kp = wide_t'($signed(d));
            CFG_KI_GAIN:       ki = wide_t'($signed(d));
            CFG_KD_GAIN:       kd = wide_t'($signed(d));
            CFG_SAMPLE_PERIOD: period = d[15:0];
            CFG_OUTPUT_LIMIT:  limit = d[30:0];
            CFG_ACCEL_RATE:    accel = d[30:0];
            CFG_DECEL_RATE:    decel = d[30:0];
            CFG_LOOP_MODE:     mode = d[0];
            default: ;
        endcase
    endtask

    // Driver: words and register writes from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        logic next_in, next_cfg;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            next_in = in_valid;
            next_cfg = cfg_valid;
            if (in_valid && in_ready)
            begin
                expected_words.push_back(pid_sample(in_data));
                words_sent++;
                next_in = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_index, cfg_data);
                cfg_writes++;
                next_cfg = 1'b0;
            end
            if (!next_in && !next_cfg && pending.size() > 0)
            begin
                if (pending[0].kind == ACT_WORD)
                begin
                    if (calm_stretch() || $urandom_range(0, 99) >= 12)
                    begin
                        in_data <= pending[0].word;
                        next_in = 1'b1;
                        void'(pending.pop_front());
                    end
                end
                else if (expected_words.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                begin
                    // Block is idle: registers may change, or the pause ends.
                    if (pending[0].kind == ACT_CFG)
                    begin
                        cfg_index <= pending[0].idx;
                        cfg_data <= pending[0].data;
                        next_cfg = 1'b1;
                    end
                    void'(pending.pop_front());
                end
            end
            in_valid <= next_in;
            cfg_valid <= next_cfg;
        end
    end

    // Monitor: random back-pressure, scoreboard, watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm_stretch() || $urandom_range(0, 99) >= 12;
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word command=%h error_now=%h",
                             $time, out_data.command, out_data.error_now);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.command !== want.command)
                    begin
                        $display("%0t: command expected %h actual %h",
                                 $time, want.command, out_data.command);
                        mismatches++;
                    end
                    if (out_data.error_now !== want.error_now)
                    begin
                        $display("%0t: error_now expected %h actual %h",
                                 $time, want.error_now, out_data.error_now);
                        mismatches++;
                    end
                end
            end
            quiet_cycles <= (expected_words.size() == 0) ? quiet_cycles + 1 : 0;
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stalled <= 0;
            else
                stalled <= stalled + 1;
            if (stalled >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d words outstanding",
                         $time, expected_words.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic add_word(logic [31:0] meas, logic [31:0] setp);
        action_t a;
        a.kind = ACT_WORD;
        a.word.measured = meas;
        a.word.setpoint = setp;
        pending.push_back(a);
    endtask

    task automatic add_cfg(cfg_index_t i, logic [31:0] d);
        action_t a;
        a.kind = ACT_CFG;
        a.idx = i;
        a.data = d;
        pending.push_back(a);
    endtask

    task automatic add_drain();
        action_t a;
        a.kind = ACT_DRAIN;
        pending.push_back(a);
    endtask

    // Value for a register: an extreme, a full-range draw, or a typical one.
    function automatic logic [31:0] pick_value(cfg_index_t i);
        int sel;
        sel = $urandom_range(0, 9);
        case (i)
            CFG_SAMPLE_PERIOD:
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1 : (sel == 2) ? 32'd65535 :
                       (sel < 6) ? $urandom_range(1, 65535) : $urandom_range(100, 3000);
            CFG_OUTPUT_LIMIT, CFG_ACCEL_RATE, CFG_DECEL_RATE:
                return (sel == 0) ? 32'd0 : (sel < 3) ? 32'h7FFF_FFFF :
                       (sel < 5) ? ($urandom() & 32'h7FFF_FFFF) : $urandom_range(1, 32'h0100_0000);
            CFG_LOOP_MODE:
                return $urandom_range(0, 1);
            default:
                return (sel == 0) ? 32'h8000_0000 : (sel == 1) ? 32'h7FFF_FFFF :
                       (sel < 4) ? $urandom() :
                       32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    initial
    begin
        int target, walk;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes at reset settings.
        add_word(32'h8000_0000, 32'h7FFF_FFFF);
        add_word(32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'h0000_0000, 32'h0000_0000);
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'h8000_0000, 32'h8000_0000);
        add_word(32'hFFFF_FFFF, 32'h0001_0000);
        // Zero sample period with every gain active: command holds.
        add_cfg(CFG_KI_GAIN, 32'h0001_0000);
        add_cfg(CFG_KD_GAIN, 32'h0000_8000);
        add_cfg(CFG_SAMPLE_PERIOD, 32'd0);
        add_word(32'h0000_0000, 32'h0010_0000);
        add_word(32'h0010_0000, 32'hFFF0_0000);
        // Tight clamp and slow slew, then a mode switch each way.
        add_cfg(CFG_SAMPLE_PERIOD, 32'd1);
        add_cfg(CFG_OUTPUT_LIMIT, 32'h0008_0000);
        add_cfg(CFG_ACCEL_RATE, 32'h0100_0000);
        add_cfg(CFG_DECEL_RATE, 32'h0000_0000);
        add_word(32'h0000_0000, 32'h7FFF_FFFF);
        add_word(32'h0000_0000, 32'h8000_0000);
        add_cfg(CFG_LOOP_MODE, MODE_VELOCITY);
        add_word(32'h0000_0000, 32'h8000_0000);
        add_word(32'h1234_5678, 32'h0000_0000);
        add_cfg(CFG_LOOP_MODE, MODE_POSITION);
        add_cfg(CFG_SAMPLE_PERIOD, 32'd65535);
        add_cfg(CFG_KP_GAIN, 32'h8000_0000);
        add_word(32'h0000_0000, 32'h0000_0000);
        add_word(32'h8000_0000, 32'h7FFF_FFFF);

        // Random phases: new register set, then a run of samples.
        for (int ph = 0; ph < 14; ph++)
        begin
            for (int r = 0; r < 8; r++)
                if ($urandom_range(0, 2) != 0 || ph == 0)
                    add_cfg(cfg_index_t'(r), pick_value(cfg_index_t'(r)));
            target = $urandom();
            walk = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            for (int k = 0; k < 84; k++)
            begin
                case ($urandom_range(0, 9))
                    0: add_word($urandom(), $urandom());
                    1: add_word($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                    default:
                    begin
                        // Measured value closing in on a fixed setpoint.
                        walk = walk - (walk >>> 3) + ($signed($urandom_range(0, 4095)) - 2048);
                        add_word(target - walk, target);
                    end
                endcase
                if (ph == 7 && k == 40)
                    add_drain();
            end
        end

        wait (pending.size() == 0 && !in_valid && !cfg_valid && expected_words.size() == 0);
        repeat (250) @(posedge clk);
        $display("Sent %0d samples, checked %0d commands, %0d register writes.",
                 words_sent, words_seen, cfg_writes);
        $display("Covered both loop modes, zero and extreme periods, clamp and slew limits.");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
